### design/rwg_pkg.sv
// Shared constants, widths and the exp(-k/4) lookup for the Ricker wavelet generator.
// No dependencies; imported by rwg_datapath and ricker_wavelet_generator_top.
package rwg_pkg;

  localparam int INDEX_W     = 16;
  localparam int STEP_W      = 24;
  localparam int SAMPLE_W    = 16;
  localparam int NUM_STAGES  = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd1317624;
  localparam int unsigned MAX_SAMPLES_DEF  = 65536;

  // pi in Q.24, rounded to nearest
  localparam logic [25:0] PI_Q24 = 26'd52707179;

  // exp(-k/4) in Q1.16, table flat at zero from k = 48 on
  function automatic logic [16:0] exp_tab(input logic [6:0] k);
    logic [16:0] v;
    case (k)
      7'd0:  v = 17'd65536;
      7'd1:  v = 17'd51039;
      7'd2:  v = 17'd39750;
      7'd3:  v = 17'd30957;
      7'd4:  v = 17'd24109;
      7'd5:  v = 17'd18776;
      7'd6:  v = 17'd14623;
      7'd7:  v = 17'd11388;
      7'd8:  v = 17'd8869;
      7'd9:  v = 17'd6907;
      7'd10: v = 17'd5380;
      7'd11: v = 17'd4190;
      7'd12: v = 17'd3263;
      7'd13: v = 17'd2541;
      7'd14: v = 17'd1979;
      7'd15: v = 17'd1541;
      7'd16: v = 17'd1200;
      7'd17: v = 17'd935;
      7'd18: v = 17'd728;
      7'd19: v = 17'd567;
      7'd20: v = 17'd442;
      7'd21: v = 17'd344;
      7'd22: v = 17'd268;
      7'd23: v = 17'd209;
      7'd24: v = 17'd162;
      7'd25: v = 17'd127;
      7'd26: v = 17'd99;
      7'd27: v = 17'd77;
      7'd28: v = 17'd60;
      7'd29: v = 17'd47;
      7'd30: v = 17'd36;
      7'd31: v = 17'd28;
      7'd32: v = 17'd22;
      7'd33: v = 17'd17;
      7'd34: v = 17'd13;
      7'd35: v = 17'd10;
      7'd36: v = 17'd8;
      7'd37: v = 17'd6;
      7'd38: v = 17'd5;
      7'd39: v = 17'd4;
      7'd40: v = 17'd3;
      7'd41: v = 17'd2;
      7'd42: v = 17'd2;
      7'd43: v = 17'd1;
      7'd44: v = 17'd1;
      7'd45: v = 17'd1;
      7'd46: v = 17'd1;
      7'd47: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### design/rwg_datapath.sv
// Eight-stage arithmetic pipeline: phase, |x|, x^2, exp lookup, interpolation, exp subtract, product, round.
// Depends on rwg_pkg; stage loads come from the valid/stall chain in the top level.
module rwg_datapath #(
  parameter int unsigned MAX_SAMPLES = rwg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic [rwg_pkg::NUM_STAGES-1:0]      stage_en,
  input  logic [rwg_pkg::STEP_W-1:0]          phase_step,
  input  logic [rwg_pkg::INDEX_W-1:0]         sample_index,
  output logic signed [rwg_pkg::SAMPLE_W-1:0] wavelet_sample
);
  import rwg_pkg::*;

  localparam logic [24:0] MAX_LIM = 25'(MAX_SAMPLES);
  localparam logic [39:0] X_LIMIT = 40'd1 << 26;
  localparam logic [29:0] XX_LIMIT = 30'd1 << 28;

  // stage 1: phase product, index range check
  logic [39:0] pos1;
  logic        zero1;
  // stage 2: |x|
  logic [26:0] ax2;
  logic        zero2;
  // stage 3: x squared
  logic [53:0] sq3;
  logic        zero3;
  // stage 4: xx and table fetch
  logic [28:0] xx4;
  logic [16:0] t0_4;
  logic [16:0] dt4;
  logic [21:0] f4;
  logic        zero4;
  // stage 5: interpolation product, polynomial term
  logic [38:0] prod5;
  logic [16:0] t0_5;
  logic [28:0] pmag5;
  logic        neg5;
  logic        zero5;
  // stage 6: exp value
  logic [16:0] e6;
  logic [28:0] pmag6;
  logic        neg6;
  logic        zero6;
  // stage 7: magnitude product
  logic [45:0] mag7;
  logic        neg7;
  logic        zero7;

  logic [39:0] diff2;
  logic [39:0] ax2_full;
  logic [53:0] sq_rnd;
  logic [29:0] xx_full;
  logic [6:0]  k4;
  logic [16:0] ta, tb;
  logic [29:0] two_xx;
  logic [29:0] pdiff;
  logic [46:0] mag_rnd;
  logic [21:0] r8;
  logic [SAMPLE_W-1:0] res8;

  always_comb begin
    diff2    = pos1 - {14'd0, PI_Q24};
    ax2_full = (pos1 >= {14'd0, PI_Q24}) ? diff2 : ({14'd0, PI_Q24} - pos1);
    sq_rnd   = sq3 + (54'd1 << 23);
    xx_full  = sq_rnd[53:24];
    k4       = xx_full[28:22];
    ta       = exp_tab(k4);
    tb       = exp_tab(k4 + 7'd1);
    two_xx   = {xx4, 1'b0};
    pdiff    = (two_xx > (30'd1 << 24)) ? (two_xx - (30'd1 << 24))
                                        : ((30'd1 << 24) - two_xx);
    mag_rnd  = {1'b0, mag7} + (47'd1 << 24);
    r8       = mag_rnd[46:25];
    if (zero7) begin
      res8 = '0;
    end else if (neg7) begin
      res8 = (r8 > 22'd32768) ? 16'h8000 : 16'(~r8 + 22'd1);
    end else begin
      res8 = (r8 > 22'd32767) ? 16'h7FFF : r8[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pos1  <= 40'(sample_index) * 40'(phase_step);
      zero1 <= {9'd0, sample_index} >= MAX_LIM;
    end
    if (stage_en[1]) begin
      ax2   <= ax2_full[26:0];
      zero2 <= zero1 || (ax2_full > X_LIMIT);
    end
    if (stage_en[2]) begin
      sq3   <= 54'(ax2) * 54'(ax2);
      zero3 <= zero2;
    end
    if (stage_en[3]) begin
      xx4   <= xx_full[28:0];
      t0_4  <= ta;
      dt4   <= ta - tb;
      f4    <= xx_full[21:0];
      zero4 <= zero3 || (xx_full > XX_LIMIT);
    end
    if (stage_en[4]) begin
      prod5 <= 39'(dt4) * 39'(f4);
      t0_5  <= t0_4;
      pmag5 <= pdiff[28:0];
      neg5  <= two_xx > (30'd1 << 24);
      zero5 <= zero4;
    end
    if (stage_en[5]) begin
      e6    <= t0_5 - prod5[38:22];
      pmag6 <= pmag5;
      neg6  <= neg5;
      zero6 <= zero5;
    end
    if (stage_en[6]) begin
      mag7  <= 46'(pmag6) * 46'(e6);
      neg7  <= neg6;
      zero7 <= zero6;
    end
    if (stage_en[7]) begin
      wavelet_sample <= res8;
    end
  end

endmodule

### design/ricker_wavelet_generator_top.sv
// Top level of the Ricker wavelet generator: ports, phase_step register, beat control.
// Depends on rwg_pkg and rwg_datapath.
//
// Each input beat carries a sample index; each output beat carries the Ricker
// wavelet exp(-x^2)*(1-2x^2) at x = index*phase_step - pi, as signed Q1.15 with
// saturation (the peak +1.0 reads as 32767). Samples with |x| > 4, x^2 > 16 or an
// index at or past MAX_SAMPLES read as zero. The block takes one beat per clock
// while in_stall is low and returns results in order through the 8-stage
// arithmetic pipeline (four multipliers for index times step, x squared, the exp
// interpolation and the final product, each followed by a register, plus the |x|,
// exp table, exp subtract and rounding stages). Each stage holds its beat only
// while the stage ahead is full and stalled, so bubbles close up and the input
// keeps flowing into any empty stages while a finished result waits at the output.
// Write phase_step (unsigned Q0.24, reset value about pi/40) only while the
// pipeline is empty.
module ricker_wavelet_generator_top #(
  parameter int unsigned MAX_SAMPLES = rwg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rwg_pkg::STEP_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rwg_pkg::INDEX_W-1:0]         sample_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rwg_pkg::SAMPLE_W-1:0] wavelet_sample
);
  import rwg_pkg::*;

  logic [STEP_W-1:0]     phase_step;
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] stage_en;

  // Configuration register, written directly
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
    end else if (cfg_we) begin
      phase_step <= cfg_wdata;
    end
  end

  // Load chain: a stage takes a new beat when it is empty or its contents move on
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      stage_en[i] = !valid[i] || stage_en[i+1];
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (stage_en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = valid[NUM_STAGES-1];

  rwg_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk            (clk),
    .stage_en       (stage_en),
    .phase_step     (phase_step),
    .sample_index   (sample_index),
    .wavelet_sample (wavelet_sample)
  );

endmodule
